>>> rtl/asxf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the cos^2 weight table of the audio source switcher.
// Used by asxf_mix and audio_source_switch_crossfade; depends on nothing.
package asxf_pkg;

    localparam int CHANNELS     = 4;
    localparam int BLOCK_LENGTH = 64;
    localparam int POS_W        = $clog2(BLOCK_LENGTH);
    localparam int SAMPLE_W     = 16;
    localparam int CH_W         = 3;
    localparam int WEIGHT_W     = 16;
    localparam int IN_FIELDS_W  = 4 * SAMPLE_W + CH_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = SAMPLE_W;
    localparam int OUT_USER_W   = 1 + CH_W;

    localparam logic [CH_W-1:0] NO_REQUEST    = CH_W'(0);
    localparam logic [CH_W-1:0] FIRST_CHANNEL = CH_W'(1);

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef longint unsigned taylor_div_t [9];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
    };

    typedef logic [WEIGHT_W-1:0] weight_rom_t [BLOCK_LENGTH];

    // Unsigned Q1.15 weight 32768*(1+cos(pi*i/BLOCK_LENGTH))/2, with the cosine
    // taken from a Taylor series through the t^18 term in Q30. Evaluated at elaboration only.
    function automatic logic [WEIGHT_W-1:0] weight_entry(int unsigned i);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned w;
        longint          c;
        longint          v;
        logic            neg;
        t   = (Q30_PI * 64'(i)) / 64'(BLOCK_LENGTH);
        neg = 1'b0;
        if (t > Q30_HALF_PI) begin
            t   = (t > Q30_PI) ? 64'd0 : Q30_PI - t;
            neg = 1'b1;
        end
        t2   = (t * t) >> 30;
        term = Q30_ONE;
        c    = longint'(Q30_ONE);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * t2) >> 30) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1) begin
                c = c - longint'(term);
            end else begin
                c = c + longint'(term);
            end
        end
        if (neg) begin
            c = -c;
        end
        v = longint'(Q30_ONE) + c;
        if (v < 0) begin
            v = 0;
        end
        w = ((64'(v) * 64'd32768) + Q30_ONE) >> 31;
        if (w > 64'd32768) begin
            w = 64'd32768;
        end
        return WEIGHT_W'(w);
    endfunction

    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        for (int i = 0; i < BLOCK_LENGTH; i++) begin
            rom[i] = weight_entry(i);
        end
        return rom;
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

    // Operands of one output sample, held in the input stage.
    typedef struct packed {
        logic                       fading;
        logic signed [SAMPLE_W-1:0] old_sample;
        logic signed [SAMPLE_W-1:0] new_sample;
        logic [WEIGHT_W-1:0]        old_weight;
        logic [WEIGHT_W-1:0]        new_weight;
    } mix_req_t;

endpackage

>>> rtl/asxf_mix.sv
`timescale 1ns / 1ps
// Crossfade arithmetic: weighted sum of old and new sample, rounded and saturated.
// Depends on asxf_pkg. Outside a fade the old sample passes through unchanged.
module asxf_mix (
    input  asxf_pkg::mix_req_t                  req,
    output logic signed [asxf_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int PROD_W = asxf_pkg::SAMPLE_W + asxf_pkg::WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - 15;

    localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(32767);
    localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(32768);

    logic signed [PROD_W-1:0] prod_old;
    logic signed [PROD_W-1:0] prod_new;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SHR_W-1:0]  shifted;

    always_comb begin
        prod_old = PROD_W'(req.old_sample) * $signed({1'b0, req.old_weight});
        prod_new = PROD_W'(req.new_sample) * $signed({1'b0, req.new_weight});
        // Adding half an LSB before the arithmetic shift rounds half up.
        sum      = SUM_W'(prod_old) + SUM_W'(prod_new) + SUM_W'(16384);
        shifted  = SHR_W'(sum >>> 15);
        if (!req.fading) begin
            sample_out = req.old_sample;
        end else if (shifted > SAT_MAX) begin
            sample_out = asxf_pkg::SAMPLE_W'(SAT_MAX);
        end else if (shifted < SAT_MIN) begin
            sample_out = asxf_pkg::SAMPLE_W'(SAT_MIN);
        end else begin
            sample_out = asxf_pkg::SAMPLE_W'(shifted);
        end
    end

endmodule

>>> rtl/audio_source_switch_crossfade.sv
`timescale 1ns / 1ps
// Audio source switcher with a cos^2 crossfade over one block of samples.
// Depends on asxf_pkg and asxf_mix.
//
// One multichannel sample is taken per clock and one routed sample comes out per
// clock while m_tready does not stall the output: the first register holds the
// channel and weight selection, the second holds the product sum after rounding
// and saturation, which is the single multiply stage of the design. A switch
// request is held until the next block start; if it names another valid channel,
// that block crossfades from the old channel to the new one and the new channel
// is active from the following block on. Outside a fade the active channel is
// passed through unchanged. The block starts on channel 1 at block position zero.
module audio_source_switch_crossfade (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, select_request, zero pad
    input  logic [asxf_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample_out
    output logic [asxf_pkg::OUT_DATA_W-1:0]  m_tdata,
    // fading, active_channel
    output logic [asxf_pkg::OUT_USER_W-1:0]  m_tuser,
    // block_end
    output logic                             m_tlast
);

    localparam int SW = asxf_pkg::SAMPLE_W;
    localparam int CW = asxf_pkg::CH_W;
    localparam int PW = asxf_pkg::POS_W;
    localparam logic [PW-1:0] LAST_POS = PW'(asxf_pkg::BLOCK_LENGTH - 1);

    // Channel state.
    logic [CW-1:0] current_reg, current_next;
    logic [CW-1:0] target_reg, target_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic [PW-1:0] pos_reg, pos_next;

    // Input stage.
    logic                 s1_valid_reg;
    asxf_pkg::mix_req_t   s1_req_reg, s1_req_next;
    logic [CW-1:0]        s1_active_reg;
    logic                 s1_last_reg;

    // Output stage.
    logic                 s2_valid_reg;
    logic [SW-1:0]        s2_sample_reg;
    logic                 s2_fading_reg;
    logic [CW-1:0]        s2_active_reg;
    logic                 s2_last_reg;

    logic          s1_advance;
    logic          s_accept;
    logic [CW-1:0] req_ch;
    logic [CW-1:0] pend_eff;
    logic          fading;
    logic          last;
    logic signed [SW-1:0] old_sample;
    logic signed [SW-1:0] new_sample;
    logic signed [SW-1:0] mix_sample;

    assign s1_advance = !s2_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    function automatic logic signed [SW-1:0] pick(
        input logic [asxf_pkg::IN_DATA_W-1:0] data,
        input logic [CW-1:0]                  ch
    );
        logic signed [SW-1:0] s;
        s = '0;
        for (int n = 0; n < 4; n++) begin
            if (n < asxf_pkg::CHANNELS && ch == CW'(n + 1)) begin
                s = data[n*SW +: SW];
            end
        end
        return s;
    endfunction

    always_comb begin
        req_ch   = s_tdata[4*SW +: CW];
        pend_eff = (req_ch != asxf_pkg::NO_REQUEST) ? req_ch : pending_reg;
        target_next  = target_reg;
        pending_next = pend_eff;
        // A held request is consumed at every block start, used or not.
        if (pos_reg == '0) begin
            if (pend_eff != asxf_pkg::NO_REQUEST &&
                pend_eff <= CW'(asxf_pkg::CHANNELS) &&
                pend_eff != current_reg) begin
                target_next = pend_eff;
            end
            pending_next = asxf_pkg::NO_REQUEST;
        end
        fading       = target_next != current_reg;
        last         = pos_reg == LAST_POS;
        current_next = (last && fading) ? target_next : current_reg;
        pos_next     = last ? '0 : pos_reg + PW'(1);

        old_sample = pick(s_tdata, current_reg);
        new_sample = pick(s_tdata, target_next);
        s1_req_next.fading     = fading;
        s1_req_next.old_sample = old_sample;
        s1_req_next.new_sample = new_sample;
        s1_req_next.old_weight = asxf_pkg::WEIGHT_ROM[pos_reg];
        s1_req_next.new_weight = asxf_pkg::WEIGHT_ROM[LAST_POS - pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg  <= asxf_pkg::FIRST_CHANNEL;
            target_reg   <= asxf_pkg::FIRST_CHANNEL;
            pending_reg  <= asxf_pkg::NO_REQUEST;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                current_reg <= current_next;
                target_reg  <= target_next;
                pending_reg <= pending_next;
                pos_reg     <= pos_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_advance) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg    <= s1_req_next;
            s1_active_reg <= current_reg;
            s1_last_reg   <= last;
        end
        if (s1_advance && s1_valid_reg) begin
            s2_sample_reg <= mix_sample;
            s2_fading_reg <= s1_req_reg.fading;
            s2_active_reg <= s1_active_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    asxf_mix u_mix (
        .req        (s1_req_reg),
        .sample_out (mix_sample)
    );

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = s2_sample_reg;
    assign m_tuser  = {s2_active_reg, s2_fading_reg};
    assign m_tlast  = s2_last_reg;

endmodule
